// ===== sv/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants for the 3x3 Prewitt edge magnitude block:
// register map, result record and the fixed-point reciprocal for the gray sum.
// ----------------------------------------------------------------------------
package pem_pkg;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EDGE_MODE    = 2'd2;

    // Edge mode codes.
    localparam logic EDGE_VERTICAL   = 1'b0;
    localparam logic EDGE_HORIZONTAL = 1'b1;

    // Register reset values.
    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

    // Division of the channel sum (at most 765) by three:
    // gray = (sum * 683) >> 11, exact over the whole range.
    localparam logic [19:0] GRAY_RECIP = 20'd683;
    localparam int          GRAY_SHIFT = 11;

    // Depth of the output queue: one entry for the word on the port, one
    // for the result leaving the compute stage and one for the item whose
    // line buffer read is in flight.
    localparam int OUTQ_DEPTH = 3;

    // One result transaction.
    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_end;
    } t_result;

endpackage

// ===== sv/prewitt_edge_magnitude_3x3_top.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_3x3_top
// Streaming 3x3 Prewitt edge magnitude over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// A result passes through the stage 1 registers and the output queue before
// it appears on the output.
// Throughput: one pixel per clock unless o_stall holds off the input, set by
// the line buffer RAM which does one read and one write-back per pixel.
// Reset (synchronous, active low) clears the counters, window and output
// queue and restores the registers; the line buffer RAM is not cleared.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_3x3_top
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    // Result output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_magnitude,
    output logic        o_frame_end,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] r_image_width;
    logic [11:0] r_image_height;
    logic        r_edge_mode;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_edge_mode    <= EDGE_VERTICAL;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[11:0];
                REG_EDGE_MODE:    r_edge_mode    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {21'd0, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {20'd0, r_image_height};
            REG_EDGE_MODE:    prdata = {31'd0, r_edge_mode};
            default:          prdata = 32'd0;
        endcase
    end

    // Last column and last row index, with the width clamped to the line
    // buffer and both dimensions raised to at least three.
    logic [11:0]   width_m1_full;
    logic [CW-1:0] width_m1;
    logic [11:0]   height_m1;

    always_comb begin
        if (r_image_width < 11'd3) begin
            width_m1_full = 12'd2;
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            width_m1_full = 12'(MAX_WIDTH - 1);
        end else begin
            width_m1_full = {1'b0, r_image_width} - 12'd1;
        end
        height_m1 = (r_image_height < 12'd3) ? 12'd2 : r_image_height - 12'd1;
    end

    assign width_m1 = width_m1_full[CW-1:0];

    // ------------------------------------------------------------------
    // Stage 0: accept, position tracking, gray conversion, RAM read
    // ------------------------------------------------------------------
    logic          accept;
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic          row_end;
    logic          frame_end;
    logic          produce;
    logic [CW-1:0] col_addr;
    logic [9:0]    rgb_sum;
    logic [19:0]   gray_prod;
    logic [7:0]    gray;

    // Stage 1 registers
    logic          r_s1_vld;
    logic [CW-1:0] r_s1_addr;
    logic [7:0]    r_s1_gray;
    logic          r_s1_prod;
    logic          r_s1_fend;
    logic          r_s1_fwd;
    logic [15:0]   r_s1_fwd_word;
    logic [15:0]   s1_wdata;
    logic          fwd_hit;

    assign accept    = i_valid && !o_stall;
    assign row_end   = (r_col >= width_m1);
    assign frame_end = row_end && (r_row >= height_m1);
    assign produce   = (r_col >= CW'(2)) && (r_row >= 12'd2);
    assign col_addr  = row_end ? width_m1 : r_col;

    // Gray = sum / 3 through a reciprocal multiply.
    assign rgb_sum   = {2'b00, i_blue} + {2'b00, i_green} + {2'b00, i_red};
    assign gray_prod = 20'(rgb_sum) * GRAY_RECIP;
    assign gray      = gray_prod[GRAY_SHIFT +: 8];

    // The entry being written back this cycle is newer than the RAM output.
    assign fwd_hit = r_s1_vld && (r_s1_addr == col_addr);

    // Column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? 12'd0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    // Stage 1 payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr     <= col_addr;
            r_s1_gray     <= gray;
            r_s1_prod     <= produce;
            r_s1_fend     <= frame_end;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_word <= s1_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: each word holds {row y-2, row y-1} for one column
    // ------------------------------------------------------------------
    logic [15:0] ram_rdata;
    logic [15:0] s1_word;
    logic [7:0]  s1_top;
    logic [7:0]  s1_mid;

    pem_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_wdata),
        .i_re    (accept),
        .i_raddr (col_addr),
        .o_rdata (ram_rdata)
    );

    assign s1_word  = r_s1_fwd ? r_s1_fwd_word : ram_rdata;
    assign s1_top   = s1_word[15:8];
    assign s1_mid   = s1_word[7:0];
    assign s1_wdata = {s1_mid, r_s1_gray};

    // ------------------------------------------------------------------
    // Stage 1: window shift and kernel response
    // ------------------------------------------------------------------
    // Window entries 0..2 are column x-2 (top, middle, bottom), 3..5 column x-1.
    logic [7:0] r_win [6];
    logic [9:0] sum_a;
    logic [9:0] sum_b;
    logic [9:0] resp_abs;
    t_result    s1_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (r_s1_vld) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_gray;
        end
    end

    // Left column minus right column, or top row minus bottom row.
    always_comb begin
        if (r_edge_mode == EDGE_VERTICAL) begin
            sum_a = {2'b00, r_win[0]} + {2'b00, r_win[1]} + {2'b00, r_win[2]};
            sum_b = {2'b00, s1_top} + {2'b00, s1_mid} + {2'b00, r_s1_gray};
        end else begin
            sum_a = {2'b00, r_win[0]} + {2'b00, r_win[3]} + {2'b00, s1_top};
            sum_b = {2'b00, r_win[2]} + {2'b00, r_win[5]} + {2'b00, r_s1_gray};
        end
        resp_abs = (sum_a >= sum_b) ? sum_a - sum_b : sum_b - sum_a;
        s1_result.magnitude = (resp_abs[9:8] != 2'b00) ? 8'd255 : resp_abs[7:0];
        s1_result.frame_end = r_s1_fend;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic       q_push;
    logic       q_pop;
    logic [1:0] q_count;
    t_result    q_head;

    assign q_push = r_s1_vld && r_s1_prod;
    assign q_pop  = o_valid && !i_stall;

    pem_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (s1_result),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_count (q_count)
    );

    // Hold off input while the queue could not take every item in flight.
    assign o_stall     = ({1'b0, q_count} + {2'b00, r_s1_vld}) >= 3'(OUTQ_DEPTH);
    assign o_valid     = (q_count != 2'd0);
    assign o_magnitude = q_head.magnitude;
    assign o_frame_end = q_head.frame_end;

endmodule

// ===== sv/pem_ram.sv =====
// ----------------------------------------------------------------------------
// pem_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module pem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pem_outq.sv =====
// ----------------------------------------------------------------------------
// pem_outq
// Small output queue that decouples the compute stage from a stalled
// downstream receiver. The head entry drives the output port directly.
// ----------------------------------------------------------------------------
module pem_outq
    import pem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_data,
    input  logic        i_pop,
    output t_result     o_data,
    output logic [1:0]  o_count
);

    t_result    r_entry [OUTQ_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] n_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] n_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Pointer and occupancy updates; pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== sv/pem_checker.sv =====
// ----------------------------------------------------------------------------
// pem_checker
// Port-level checks for the Prewitt edge magnitude block, bound to the top.
// ----------------------------------------------------------------------------
module pem_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_magnitude,
    input logic       o_frame_end
);

    // Reset leaves the output empty and the input open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output or stall active after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_magnitude)
                                  && $stable(o_frame_end)))
        else $error("stalled result changed");

    // With nothing waiting at the output the input is never held off.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output queue empty");

    // A result only follows a pixel transaction that went through stage 1 earlier.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result appeared without a pixel transaction");

endmodule

bind prewitt_edge_magnitude_3x3_top pem_checker u_pem_checker (.*);

// ===== sim/tb_prewitt_edge_magnitude_3x3_top.sv =====
// ----------------------------------------------------------------------------
// tb_prewitt_edge_magnitude_3x3_top
// Self-checking bench for the streaming 3x3 Prewitt edge magnitude block.
// A driver feeds RGB pixel transactions from a queue and predicts each edge
// magnitude as the pixel is accepted. A monitor compares every result
// transaction with the oldest prediction. The run covers small directed
// frames, random frames of many sizes and both kernels, register writes in
// the middle of a frame and a wider line, under four idling patterns.
// ----------------------------------------------------------------------------
module tb_prewitt_edge_magnitude_3x3_top
    import pem_pkg::*;
();

    localparam int LINE_MAX      = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        o_stall;
    logic [7:0]  i_blue    = '0;
    logic [7:0]  i_green   = '0;
    logic [7:0]  i_red     = '0;
    logic        o_valid;
    logic        i_stall   = 1'b0;
    logic [7:0]  o_magnitude;
    logic        o_frame_end;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    prewitt_edge_magnitude_3x3_top #(
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_magnitude (o_magnitude),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Pixels waiting to be driven and edge magnitudes waiting to arrive.
    t_rgb    pixel_queue[$];
    t_result magnitude_queue[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    t_rgb    next_pixel;
    t_result expected_res;

    // Local copy of the block's registers and image state.
    logic [10:0] cfg_width  = IMAGE_WIDTH_RST;
    logic [11:0] cfg_height = IMAGE_HEIGHT_RST;
    logic        cfg_mode   = EDGE_VERTICAL;
    bit   [7:0]  upper_line [0:LINE_MAX-1];
    bit   [7:0]  lower_line [0:LINE_MAX-1];
    bit   [7:0]  window_px  [0:5];
    int unsigned col_count = 0;
    int unsigned row_count = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advances the image state by one pixel and queues the edge magnitude
    // that the pixel completes, if its 3x3 window lies inside the frame.
    task automatic predict_pixel(input t_rgb px);
        int unsigned w, h, x, gray, top, mid;
        int          sum_a, sum_b, resp;
        bit          row_end, last_in_frame;
        t_result     res;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > LINE_MAX) w = LINE_MAX;
        h = cfg_height;
        if (h < 3) h = 3;
        x = col_count;
        if (x >= w) x = w - 1;

        gray = (32'(px.blue) + 32'(px.green) + 32'(px.red)) / 3;
        top  = upper_line[x];
        mid  = lower_line[x];

        row_end       = (col_count >= w - 1);
        last_in_frame = row_end && (row_count >= h - 1);

        if (col_count >= 2 && row_count >= 2) begin
            if (cfg_mode == EDGE_VERTICAL) begin
                sum_a = window_px[0] + window_px[1] + window_px[2];
                sum_b = top + mid + gray;
            end else begin
                sum_a = window_px[0] + window_px[3] + top;
                sum_b = window_px[2] + window_px[5] + gray;
            end
            resp = sum_a - sum_b;
            if (resp < 0) resp = -resp;
            res.magnitude = (resp > 255) ? 8'd255 : 8'(resp);
            res.frame_end = last_in_frame;
            magnitude_queue.push_back(res);
        end

        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = 8'(top);
        window_px[4] = 8'(mid);
        window_px[5] = 8'(gray);

        upper_line[x] = 8'(mid);
        lower_line[x] = 8'(gray);

        if (row_end) begin
            col_count = 0;
            if (last_in_frame) row_count = 0;
            else row_count = (row_count + 1) & 32'hFFF;
        end else begin
            col_count = col_count + 1;
        end
    endtask

    // Driver: predicts on each accepted pixel transaction and presents the
    // next pending pixel unless the sender chooses to idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_pixel(t_rgb'({i_blue, i_green, i_red}));
            if (!i_valid || !o_stall) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pixel = pixel_queue.pop_front();
                    i_valid <= 1'b1;
                    i_blue  <= next_pixel.blue;
                    i_green <= next_pixel.green;
                    i_red   <= next_pixel.red;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result transaction and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (magnitude_queue.size() == 0) begin
                    $display("%0t: unexpected result, magnitude %0d frame_end %0b",
                             $time, o_magnitude, o_frame_end);
                    mismatch_count++;
                end else begin
                    expected_res = magnitude_queue.pop_front();
                    if (o_magnitude !== expected_res.magnitude) begin
                        $display("%0t: magnitude expected %0d actual %0d",
                                 $time, expected_res.magnitude, o_magnitude);
                        mismatch_count++;
                    end
                    if (o_frame_end !== expected_res.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, expected_res.frame_end, o_frame_end);
                        mismatch_count++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, magnitude_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Register write over the configuration port: setup then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {2'b00, idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = value[10:0];
            REG_IMAGE_HEIGHT: cfg_height = value[11:0];
            REG_EDGE_MODE:    cfg_mode   = value[0];
            default: ;
        endcase
    endtask

    // Waits until every pixel has gone in and every magnitude has come out,
    // then lets the pipeline empty of pixels that give no result.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || i_valid || magnitude_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode idling);
        case (idling)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 56; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pixel_queue.push_back('{blue: b, green: g, red: r});
    endtask

    // Random pixels: half fully random, the rest dark or bright patches so
    // that strong edges and saturation occur often.
    task automatic queue_random_pixels(input int count);
        t_rgb px;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0, 1: px = t_rgb'(24'($urandom));
                2: begin
                    px.blue  = 8'($urandom_range(15));
                    px.green = 8'($urandom_range(15));
                    px.red   = 8'($urandom_range(15));
                end
                default: begin
                    px.blue  = 8'($urandom_range(255, 240));
                    px.green = 8'($urandom_range(255, 240));
                    px.red   = 8'($urandom_range(255, 240));
                end
            endcase
            pixel_queue.push_back(px);
        end
    endtask

    // Writes all three registers, then sends whole frames of random pixels.
    task automatic run_frames(input logic [31:0] width_val, input logic [31:0] height_val,
                              input logic mode_val, input int frames,
                              input t_idle_mode idling);
        int unsigned wc, hc;
        set_idling(idling);
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
        write_reg(REG_EDGE_MODE, {31'b0, mode_val});
        wc = width_val[10:0];
        if (wc < 3) wc = 3;
        if (wc > LINE_MAX) wc = LINE_MAX;
        hc = height_val[11:0];
        if (hc < 3) hc = 3;
        queue_random_pixels(wc * hc * frames);
        wait_idle();
    endtask

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame, widths and heights below range are
        // raised to three. Bright left column against dark right column.
        set_idling(IDLE_NONE);
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_VERTICAL});
        repeat (3) begin
            queue_pixel(8'd255, 8'd255, 8'd255);
            queue_pixel(8'd255, 8'd255, 8'd255);
            queue_pixel(8'd0, 8'd0, 8'd0);
        end
        wait_idle();

        // Directed: horizontal kernel, dark top row and bright bottom row,
        // one channel at full scale in the middle; the unmapped index is
        // written and must change nothing.
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_HORIZONTAL});
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        repeat (3) queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        repeat (3) queue_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();

        // Directed: vertical kernel with a small response and gray values
        // that truncate on the division by three.
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_VERTICAL});
        queue_pixel(8'd1, 8'd1, 8'd0);
        queue_pixel(8'd128, 8'd64, 8'd32);
        queue_pixel(8'd10, 8'd10, 8'd10);
        queue_pixel(8'd2, 8'd2, 8'd1);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd20, 8'd20, 8'd22);
        queue_pixel(8'd2, 8'd2, 8'd3);
        queue_pixel(8'd255, 8'd255, 8'd254);
        queue_pixel(8'd30, 8'd31, 8'd31);
        wait_idle();

        // Random frames of small sizes, both kernels, every idling pattern.
        for (int p = 0; p < 13; p++) begin
            run_frames($urandom_range(12), $urandom_range(8),
                       $urandom_range(1) ? EDGE_HORIZONTAL : EDGE_VERTICAL,
                       $urandom_range(2, 1), t_idle_mode'(p % 4));
        end

        // Tallest frame: a few rows, then the height is cut mid-frame so the
        // frame closes at the end of the next row.
        set_idling(IDLE_SENDER);
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd4095);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_HORIZONTAL});
        queue_random_pixels(24);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 32'd3);
        queue_random_pixels(3);
        wait_idle();

        // Width narrowed in the middle of a row: the row ends at once and
        // the last row of the frame uses the new width.
        set_idling(IDLE_RECEIVER);
        write_reg(REG_IMAGE_WIDTH, 32'd10);
        write_reg(REG_IMAGE_HEIGHT, 32'd4);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_VERTICAL});
        queue_random_pixels(27);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 32'd4);
        queue_random_pixels(5);
        wait_idle();

        // Kernel switched halfway through a frame.
        set_idling(IDLE_BOTH);
        write_reg(REG_IMAGE_WIDTH, 32'd6);
        write_reg(REG_IMAGE_HEIGHT, 32'd5);
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_VERTICAL});
        queue_random_pixels(15);
        wait_idle();
        write_reg(REG_EDGE_MODE, {31'b0, EDGE_HORIZONTAL});
        queue_random_pixels(15);
        wait_idle();

        // A wider line than the random frames use.
        run_frames(32'd24, 32'd3, EDGE_VERTICAL, 1, IDLE_BOTH);

        wait_idle();
        if (mismatch_count == 0 && magnitude_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
